### design/sfla_pkg.sv
package sfla_pkg;

    localparam int HEAP_ADDR_BITS_DEF = 20;
    localparam int CLASS_COUNT        = 14;
    localparam int CLASS_W            = 4;
    localparam int BYTES_W            = 13;
    localparam int ADDR_W             = 20;
    localparam int SIZE_W             = 21;
    localparam int FREE_BYTES_W       = 24;
    localparam int FREE_BLOCKS_W      = 20;
    localparam int S_TDATA_W          = 48;
    localparam int S_TUSER_W          = 2;
    localparam int M_TDATA_W          = 64;
    localparam int M_TUSER_W          = 1;

    localparam logic [CLASS_W-1:0] CLASS_NONE = CLASS_W'(CLASS_COUNT);
    localparam logic [BYTES_W-1:0] MIN_BLOCK  = 13'd16;

    typedef enum logic [1:0] {
        KIND_FREE  = 2'd0,
        KIND_ALLOC = 2'd1,
        KIND_CLEAR = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec_free;
        logic exec_clear;
        logic exec_read;
        logic pop;
        logic split;
        logic load_out;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        kind_t kind;
        logic  hit;
        logic  split_ok;
        logic  out_free;
    } stat_t;

    function automatic logic [BYTES_W-1:0] class_size(input logic [CLASS_W-1:0] idx);
        logic [BYTES_W-1:0] sz;
        case (idx)
            4'd0:    sz = 13'd16;
            4'd1:    sz = 13'd32;
            4'd2:    sz = 13'd48;
            4'd3:    sz = 13'd64;
            4'd4:    sz = 13'd96;
            4'd5:    sz = 13'd128;
            4'd6:    sz = 13'd192;
            4'd7:    sz = 13'd256;
            4'd8:    sz = 13'd384;
            4'd9:    sz = 13'd512;
            4'd10:   sz = 13'd768;
            4'd11:   sz = 13'd1024;
            4'd12:   sz = 13'd2048;
            4'd13:   sz = 13'd4096;
            default: sz = 13'd0;
        endcase
        return sz;
    endfunction

    // Smallest class that holds the size; CLASS_NONE when over the largest
    function automatic logic [CLASS_W-1:0] class_of(input logic [SIZE_W-1:0] bytes);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_NONE;
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (bytes <= SIZE_W'(class_size(CLASS_W'(i))))
            begin
                cls = CLASS_W'(i);
            end
        end
        return cls;
    endfunction

endpackage

### design/sfla_ctrl.sv
module sfla_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  sfla_pkg::stat_t   stat,
    output sfla_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EXEC  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_SPLIT = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (stat.kind)
                    sfla_pkg::KIND_FREE:  cmd.exec_free  = 1'b1;
                    sfla_pkg::KIND_CLEAR: cmd.exec_clear = 1'b1;
                    sfla_pkg::KIND_ALLOC:
                    begin
                        if (stat.hit)
                        begin
                            cmd.exec_read = 1'b1;
                            state_next    = ST_READ;
                        end
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_READ:
            begin
                cmd.pop    = 1'b1;
                state_next = stat.split_ok ? ST_SPLIT : ST_DONE;
            end
            ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold the result until the output register is free
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

### design/sfla_datapath.sv
module sfla_datapath
#(
    parameter int HEAP_ADDR_BITS = sfla_pkg::HEAP_ADDR_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [sfla_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [sfla_pkg::S_TUSER_W-1:0]   s_tuser,
    input  sfla_pkg::cmd_t                   cmd,
    output sfla_pkg::stat_t                  stat,
    input  logic                             m_tready,
    output logic                             m_tvalid,
    output logic [sfla_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [sfla_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int SLOT_W  = HEAP_ADDR_BITS - 4;
    localparam int DEPTH   = 2 ** SLOT_W;
    localparam int EXT_W   = (HEAP_ADDR_BITS > sfla_pkg::ADDR_W) ?
                             HEAP_ADDR_BITS : sfla_pkg::ADDR_W;
    localparam int BW      = sfla_pkg::BYTES_W;
    localparam int CW      = sfla_pkg::CLASS_W;
    localparam int ENTRY_W = SLOT_W + BW;
    localparam int FBY_W   = sfla_pkg::FREE_BYTES_W;
    localparam int FBL_W   = sfla_pkg::FREE_BLOCKS_W;

    // input word
    sfla_pkg::kind_t                kind_reg;
    logic [SLOT_W-1:0]              slot_reg;
    logic [sfla_pkg::SIZE_W-1:0]    size_reg;
    logic [sfla_pkg::ADDR_W-1:0]    addr_in;
    logic [EXT_W-1:0]               addr_ext;

    // list heads and link memory
    logic [SLOT_W-1:0]              head_reg [sfla_pkg::CLASS_COUNT];
    logic [ENTRY_W-1:0]             mem [DEPTH];
    logic [ENTRY_W-1:0]             rd_reg;

    logic [sfla_pkg::CLASS_COUNT-1:0] nonempty;
    logic [CW-1:0]                  want;
    logic [CW-1:0]                  found;
    logic                           hit;
    logic [CW-1:0]                  head_idx;
    logic [SLOT_W-1:0]              head_rd;

    logic [CW-1:0]                  sel_reg;
    logic [CW-1:0]                  want_reg;
    logic [SLOT_W-1:0]              pop_slot_reg;

    // push unit
    logic [SLOT_W-1:0]              push_slot;
    logic [sfla_pkg::SIZE_W-1:0]    push_bytes;
    logic [CW-1:0]                  push_cls;
    logic                           push_go;
    logic                           push_file;

    // pop and split
    logic [SLOT_W-1:0]              rd_link;
    logic [BW-1:0]                  rd_bytes;
    logic [BW-1:0]                  want_cs;
    logic [BW-1:0]                  rem_calc;
    logic [SLOT_W-1:0]              rslot_calc;
    logic [BW-1:0]                  rem_reg;
    logic [SLOT_W-1:0]              rem_slot_reg;

    // counters
    logic [FBY_W-1:0]               bytes_reg;
    logic [FBY_W-1:0]               bytes_next;
    logic [FBL_W-1:0]               blocks_reg;
    logic [FBL_W-1:0]               blocks_next;
    logic [FBY_W:0]                 bytes_sum;

    // result and output register
    logic [sfla_pkg::ADDR_W-1:0]    res_addr_reg;
    logic                           res_ok_reg;
    logic [EXT_W-1:0]               pop_addr_ext;
    logic                           out_valid_reg;
    logic [sfla_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [sfla_pkg::M_TUSER_W-1:0] out_user_reg;

    assign addr_in  = s_tdata[sfla_pkg::ADDR_W-1:0];
    assign addr_ext = EXT_W'(addr_in);

    // class search: lowest non-empty class at or above the request
    assign want = sfla_pkg::class_of(size_reg);

    always_comb
    begin
        found = '0;
        hit   = 1'b0;
        for (int i = sfla_pkg::CLASS_COUNT - 1; i >= 0; i--) begin
            nonempty[i] = (head_reg[i] != '0);
            if (nonempty[i] && (CW'(i) >= want))
            begin
                found = CW'(i);
                hit   = 1'b1;
            end
        end
    end

    assign push_slot  = cmd.split ? rem_slot_reg : slot_reg;
    assign push_bytes = cmd.split ? sfla_pkg::SIZE_W'(rem_reg) : size_reg;
    assign push_cls   = sfla_pkg::class_of(push_bytes);
    assign push_go    = (cmd.exec_free && (slot_reg != '0)) || cmd.split;
    assign push_file  = push_go && (push_cls != sfla_pkg::CLASS_NONE);

    assign head_idx = cmd.exec_read ? found : push_cls;
    assign head_rd  = (head_idx < CW'(sfla_pkg::CLASS_COUNT)) ? head_reg[head_idx] : '0;

    assign rd_link    = rd_reg[ENTRY_W-1:BW];
    assign rd_bytes   = rd_reg[BW-1:0];
    assign want_cs    = sfla_pkg::class_size(want_reg);
    assign rem_calc   = (rd_bytes > want_cs) ? rd_bytes - want_cs : '0;
    assign rslot_calc = pop_slot_reg + SLOT_W'(want_cs[BW-1:4]);

    assign stat.kind     = kind_reg;
    assign stat.hit      = hit;
    assign stat.split_ok = (sel_reg > want_reg) && (rem_calc >= sfla_pkg::MIN_BLOCK) &&
                           (rslot_calc != '0);
    assign stat.out_free = !out_valid_reg || m_tready;

    // list heads
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < sfla_pkg::CLASS_COUNT; i++) begin
                head_reg[i] <= '0;
            end
        end
        else if (cmd.exec_clear)
        begin
            for (int i = 0; i < sfla_pkg::CLASS_COUNT; i++) begin
                head_reg[i] <= '0;
            end
        end
        else if (push_file)
        begin
            head_reg[push_cls] <= push_slot;
        end
        else if (cmd.pop)
        begin
            head_reg[sel_reg] <= rd_link;
        end
    end

    // link memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (push_file)
        begin
            mem[push_slot] <= {head_rd, push_bytes[BW-1:0]};
        end
        if (cmd.exec_read)
        begin
            rd_reg <= mem[head_rd];
        end
    end

    // saturating counters
    assign bytes_sum = {1'b0, bytes_reg} + (FBY_W + 1)'(push_bytes);

    always_comb
    begin
        bytes_next  = bytes_reg;
        blocks_next = blocks_reg;
        if (cmd.exec_clear)
        begin
            bytes_next  = '0;
            blocks_next = '0;
        end
        else if (push_go)
        begin
            bytes_next  = bytes_sum[FBY_W] ? '1 : bytes_sum[FBY_W-1:0];
            blocks_next = (blocks_reg != '1) ? blocks_reg + 1'b1 : blocks_reg;
        end
        else if (cmd.pop)
        begin
            bytes_next  = (bytes_reg > FBY_W'(rd_bytes)) ? bytes_reg - FBY_W'(rd_bytes) : '0;
            blocks_next = (blocks_reg != '0) ? blocks_reg - 1'b1 : blocks_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg  <= '0;
            blocks_reg <= '0;
        end
        else
        begin
            bytes_reg  <= bytes_next;
            blocks_reg <= blocks_next;
        end
    end

    assign pop_addr_ext = EXT_W'({pop_slot_reg, 4'b0000});

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg     <= sfla_pkg::kind_t'(s_tuser);
            slot_reg     <= addr_ext[HEAP_ADDR_BITS-1:4];
            size_reg     <= s_tdata[sfla_pkg::ADDR_W +: sfla_pkg::SIZE_W];
            res_addr_reg <= '0;
            res_ok_reg   <= 1'b0;
        end
        if (cmd.exec_read)
        begin
            sel_reg      <= found;
            want_reg     <= want;
            pop_slot_reg <= head_rd;
        end
        if (cmd.pop)
        begin
            rem_reg      <= rem_calc;
            rem_slot_reg <= rslot_calc;
            res_addr_reg <= pop_addr_ext[sfla_pkg::ADDR_W-1:0];
            res_ok_reg   <= 1'b1;
        end
        if (cmd.load_out)
        begin
            out_data_reg <= {blocks_reg, bytes_reg, res_addr_reg};
            out_user_reg <= res_ok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

### design/segregated_free_list_allocator_top.sv
// Segregated free-list allocator with block splitting.
// Input channel (s_*): one word per command. s_tuser carries the kind
// (free, allocate, clear, no-op); s_tdata carries the block address and size.
// Output channel (m_*): one word per command, in order: allocated address,
// running free byte and free block counts; m_tuser flags a successful allocate.
// Timing: the input is taken in the idle cycle, then the controller runs
// EXEC (decode, push or class search), READ (pop from the link memory),
// SPLIT (file the remainder) and DONE (load the output register).
// A free, clear, no-op or failed allocate passes through EXEC and DONE only,
// an allocate adds READ and one that splits adds SPLIT; the registered read of
// the link memory sets the extra READ state before the pop.
// The output register holds a finished word; a new word is taken while it
// waits. If the receiver stalls, the next result waits in DONE and s_tready
// stays low until the output register frees up.
// Reset clears the list heads, the counters and the controller. The link
// memory needs no clearing pass: entries are only read after being written.
module segregated_free_list_allocator_top
#(
    parameter int HEAP_ADDR_BITS = sfla_pkg::HEAP_ADDR_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [19:0] addr, [40:20] size, [47:41] zero
    input  logic [sfla_pkg::S_TDATA_W-1:0]   s_tdata,
    // [1:0] kind
    input  logic [sfla_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [19:0] alloc_addr, [43:20] free_bytes, [63:44] free_blocks
    output logic [sfla_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] alloc_ok
    output logic [sfla_pkg::M_TUSER_W-1:0]   m_tuser
);

    sfla_pkg::cmd_t  cmd;
    sfla_pkg::stat_t stat;

    // sequencing: one command word at a time
    sfla_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // heads, link memory, counters and output register
    sfla_datapath
    #(
        .HEAP_ADDR_BITS (HEAP_ADDR_BITS)
    )
    u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // never overwrite a result the receiver has not taken
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output register loaded while a word is pending");

    // one word in flight: accept closes the input until the result is loaded
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted twice in a row");

    // a split only follows a pop
    a_split_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.split |-> $past(cmd.pop))
        else $error("split without a preceding pop");

    // at most one datapath command per cycle
    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_in, cmd.exec_free, cmd.exec_clear, cmd.exec_read,
                  cmd.pop, cmd.split, cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule

### tb/sv/tb_segregated_free_list_allocator_top.sv
module tb_segregated_free_list_allocator_top;

    import sfla_pkg::*;

    localparam int          SLOT_W       = ADDR_W - 4;
    localparam int unsigned SLOT_TOTAL   = 1 << SLOT_W;
    localparam int unsigned BYTES_CAP    = (1 << FREE_BYTES_W) - 1;
    localparam int unsigned BLOCKS_CAP   = (1 << FREE_BLOCKS_W) - 1;
    localparam int unsigned SIZE_TOP     = 1048576;
    localparam int unsigned RANDOM_WORDS = 2000;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned REPORT_MAX   = 10;

    localparam int unsigned CLASS_BYTES [CLASS_COUNT] = '{
        16, 32, 48, 64, 96, 128, 192, 256, 384, 512, 768, 1024, 2048, 4096
    };

    // One result word as the allocator reports it
    typedef struct packed {
        logic [ADDR_W-1:0]        addr;
        logic                     ok;
        logic [FREE_BYTES_W-1:0]  bytes;
        logic [FREE_BLOCKS_W-1:0] blocks;
    } heap_resp_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    // Shadow heap: list heads, link and size memories, running counters
    logic [SLOT_W-1:0]  list_head [CLASS_COUNT] = '{default: '0};
    logic [SLOT_W-1:0]  slot_link [SLOT_TOTAL];
    logic [BYTES_W-1:0] slot_bytes [SLOT_TOTAL];
    int unsigned        byte_total  = 0;
    int unsigned        block_total = 0;

    heap_resp_t  heap_resp_q [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;
    bit          quiet          = 1'b0;

    segregated_free_list_allocator_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Smallest class that holds the byte count; CLASS_COUNT when none does
    function automatic int size_class_index(int unsigned bytes);
        int cls;
        cls = CLASS_COUNT;
        for (int i = CLASS_COUNT - 1; i >= 0; i--)
        begin
            if (bytes <= CLASS_BYTES[i])
            begin
                cls = i;
            end
        end
        return cls;
    endfunction

    function automatic void count_block_in(int unsigned bytes);
        byte_total = (byte_total + bytes > BYTES_CAP) ? BYTES_CAP : byte_total + bytes;
        if (block_total < BLOCKS_CAP)
        begin
            block_total++;
        end
    endfunction

    // Push onto the head of a class list and count the block as free
    function automatic void file_block(logic [SLOT_W-1:0] slot, int unsigned bytes, int cls);
        slot_bytes[slot] = BYTES_W'(bytes);
        slot_link[slot]  = list_head[cls];
        list_head[cls]   = slot;
        count_block_in(bytes);
    endfunction

    // Advance the shadow heap by one command word and return the word it should answer
    function automatic heap_resp_t heap_step(kind_t kind, logic [ADDR_W-1:0] addr,
                                             logic [SIZE_W-1:0] size);
        heap_resp_t        resp;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] rem_slot;
        int                want;
        int                cls;
        bit                found;
        int unsigned       have;
        int unsigned       rem;
        resp  = '0;
        found = 1'b0;
        case (kind)
            KIND_FREE:
            begin
                // Slot zero doubles as the empty marker, so drop such a free
                slot = addr[ADDR_W-1:4];
                if (slot != '0)
                begin
                    cls = size_class_index(size);
                    if (cls >= CLASS_COUNT)
                    begin
                        count_block_in(size);
                    end
                    else
                    begin
                        file_block(slot, size, cls);
                    end
                end
            end
            KIND_ALLOC:
            begin
                want = size_class_index(size);
                for (int i = want; i < CLASS_COUNT && !found; i++)
                begin
                    slot = list_head[i];
                    if (slot != '0)
                    begin
                        found        = 1'b1;
                        list_head[i] = slot_link[slot];
                        have         = int'(slot_bytes[slot]);
                        byte_total   = (byte_total > have) ? byte_total - have : 0;
                        if (block_total > 0)
                        begin
                            block_total--;
                        end
                        // Split a larger block; a remainder that wraps to slot zero is lost
                        rem      = (have > CLASS_BYTES[want]) ? have - CLASS_BYTES[want] : 0;
                        rem_slot = slot + SLOT_W'(CLASS_BYTES[want] >> 4);
                        if (i > want && rem >= CLASS_BYTES[0] && rem_slot != '0)
                        begin
                            file_block(rem_slot, rem, size_class_index(rem));
                        end
                        resp.addr = {slot, 4'b0000};
                        resp.ok   = 1'b1;
                    end
                end
            end
            KIND_CLEAR:
            begin
                foreach (list_head[i])
                begin
                    list_head[i] = '0;
                end
                byte_total  = 0;
                block_total = 0;
            end
            default:
            begin
            end
        endcase
        resp.bytes  = FREE_BYTES_W'(byte_total);
        resp.blocks = FREE_BLOCKS_W'(block_total);
        return resp;
    endfunction

    // Offer one command word, hold it until taken, then log its expected answer
    task automatic send_word(kind_t kind, logic [ADDR_W-1:0] addr, logic [SIZE_W-1:0] size);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_TDATA_W - SIZE_W - ADDR_W){1'b0}}, size, addr};
        do
            @(posedge clk);
        while (!s_tready);
        heap_resp_q.push_back(heap_step(kind, addr, size));
        @(negedge clk);
    endtask

    // Stop offering words until every answer is back
    task automatic drain_heap();
        s_tvalid <= 1'b0;
        while (heap_resp_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Half the time a narrow window of slots, so addresses repeat and split remainders collide
    function automatic logic [ADDR_W-1:0] pick_block_addr();
        if ($urandom_range(0, 1) == 0)
        begin
            return {SLOT_W'($urandom_range(1, 255)), 4'b0000};
        end
        return {SLOT_W'($urandom_range(1, SLOT_TOTAL - 1)), 4'b0000};
    endfunction

    // Favor sizes on and next to the class bounds
    function automatic logic [SIZE_W-1:0] pick_block_size();
        int c;
        c = $urandom_range(0, CLASS_COUNT - 1);
        case ($urandom_range(0, 3))
            0:       return SIZE_W'(CLASS_BYTES[c]);
            1:       return SIZE_W'(CLASS_BYTES[c] + 1);
            2:       return SIZE_W'(CLASS_BYTES[c] - 1);
            default: return SIZE_W'($urandom_range(1, 4096));
        endcase
    endfunction

    task automatic test_empty_heap();
        send_word(KIND_ALLOC, '0, SIZE_W'(16));
        send_word(KIND_ALLOC, '1, SIZE_W'(4097));
        send_word(KIND_ALLOC, '0, SIZE_W'(0));
        send_word(KIND_ALLOC, '0, SIZE_W'(SIZE_TOP));
        drain_heap();
    endtask

    task automatic test_free_corners();
        send_word(KIND_FREE, ADDR_W'('h0000F), SIZE_W'(64));
        send_word(KIND_FREE, ADDR_W'('h00010), SIZE_W'(0));
        send_word(KIND_FREE, ADDR_W'('hFFFF0), SIZE_W'(4096));
        send_word(KIND_FREE, ADDR_W'('h12340), SIZE_W'(4097));
        send_word(KIND_FREE, ADDR_W'('h23450), SIZE_W'(SIZE_TOP));
        send_word(KIND_NOP, '1, '1);
        send_word(KIND_ALLOC, '0, SIZE_W'(0));
        drain_heap();
    endtask

    task automatic test_split_and_wrap();
        send_word(KIND_CLEAR, '0, '0);
        // Remainder of the top block wraps to slot zero and is dropped
        send_word(KIND_FREE, ADDR_W'('hFFFF0), SIZE_W'(4096));
        send_word(KIND_ALLOC, '0, SIZE_W'(16));
        // Remainder under one slot is dropped
        send_word(KIND_FREE, ADDR_W'('h00400), SIZE_W'(20));
        send_word(KIND_ALLOC, '0, SIZE_W'(1));
        // Remainder refiled, then taken back by an exact-class request
        send_word(KIND_FREE, ADDR_W'('h01000), SIZE_W'(4096));
        send_word(KIND_ALLOC, '0, SIZE_W'(48));
        send_word(KIND_ALLOC, '0, SIZE_W'(4096));
        drain_heap();
    endtask

    task automatic test_relink_underflow();
        // A double free links the slot to itself; a third pop must hold the counts at zero
        send_word(KIND_CLEAR, '0, '0);
        send_word(KIND_FREE, ADDR_W'('h00200), SIZE_W'(16));
        send_word(KIND_FREE, ADDR_W'('h00200), SIZE_W'(16));
        repeat (3) send_word(KIND_ALLOC, '0, SIZE_W'(16));
        drain_heap();
    endtask

    task automatic test_random_traffic(int unsigned word_total);
        int unsigned sent;
        int          pick;
        int          burst;
        bit          paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < word_total)
        begin
            if (!paused && sent >= word_total / 2)
            begin
                drain_heap();
                paused = 1'b1;
            end
            if (sent >= word_total * 9 / 10)
            begin
                quiet = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                // Flood of oversize frees pushes the byte count toward saturation
                burst = $urandom_range(16, 20);
                repeat (burst)
                    send_word(KIND_FREE, pick_block_addr(), SIZE_W'($urandom_range(4097, SIZE_TOP)));
            end
            else if (pick < 7)
            begin
                burst = 1;
                send_word(KIND_CLEAR, ADDR_W'($urandom), SIZE_W'($urandom));
            end
            else if (pick < 20)
            begin
                burst = $urandom_range(3, 8);
                repeat (burst)
                    send_word(kind_t'($urandom_range(0, 3)), ADDR_W'($urandom),
                              SIZE_W'($urandom_range(0, SIZE_TOP)));
            end
            else if (pick < 40)
            begin
                // Large blocks first, then small requests that can split them
                burst = $urandom_range(2, 5);
                repeat (burst)
                    send_word(KIND_FREE, pick_block_addr(), SIZE_W'($urandom_range(1025, 4096)));
                repeat ($urandom_range(2, 6))
                begin
                    send_word(KIND_ALLOC, ADDR_W'($urandom), SIZE_W'($urandom_range(1, 512)));
                    burst++;
                end
            end
            else
            begin
                burst = $urandom_range(4, 12);
                repeat (burst)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        send_word(KIND_FREE, pick_block_addr(), pick_block_size());
                    end
                    else
                    begin
                        send_word(KIND_ALLOC, ADDR_W'($urandom), pick_block_size());
                    end
                end
            end
            sent += burst;
        end
        drain_heap();
    endtask

    // Receiver: random stalls, none once the run goes quiet
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && !quiet && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // Compare every result word against the oldest expected answer
    always @(posedge clk)
    begin
        heap_resp_t seen;
        heap_resp_t wanted;
        if (m_tvalid && m_tready)
        begin
            seen.addr   = m_tdata[ADDR_W-1:0];
            seen.ok     = m_tuser[0];
            seen.bytes  = m_tdata[ADDR_W +: FREE_BYTES_W];
            seen.blocks = m_tdata[ADDR_W + FREE_BYTES_W +: FREE_BLOCKS_W];
            if (heap_resp_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                begin
                    $display("%0t: unexpected word addr=%h ok=%b bytes=%0d blocks=%0d",
                             $time, seen.addr, seen.ok, seen.bytes, seen.blocks);
                end
            end
            else
            begin
                wanted = heap_resp_q.pop_front();
                if (seen !== wanted)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("%0t: mismatch expected addr=%h ok=%b bytes=%0d blocks=%0d",
                                 $time, wanted.addr, wanted.ok, wanted.bytes, wanted.blocks);
                        $display("%0t:            actual addr=%h ok=%b bytes=%0d blocks=%0d",
                                 $time, seen.addr, seen.ok, seen.bytes, seen.blocks);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_heap();
        test_free_corners();
        test_split_and_wrap();
        test_relink_underflow();
        test_random_traffic(RANDOM_WORDS);
        // Let any stray word show up before the verdict
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### segregated_free_list_allocator_top.f
design/sfla_pkg.sv
design/sfla_ctrl.sv
design/sfla_datapath.sv
design/segregated_free_list_allocator_top.sv
tb/sv/tb_segregated_free_list_allocator_top.sv
